/* rtl/core/tit_pkg.sv */
`timescale 1ns / 1ps

package tit_pkg;

  localparam int unsigned ExpW   = 5;
  localparam int unsigned CountW = 8;
  localparam int unsigned DelayW = 32;
  localparam int unsigned RandW  = 16;

  localparam logic [ExpW-1:0]   ExpCap       = 5'd22;
  localparam logic [CountW-1:0] CountMax     = 8'd255;
  // half of the 1000-unit base interval
  localparam logic [9:0]        HalfUnit     = 10'd500;
  localparam logic [10:0]       Unit         = 11'd1000;

  localparam logic [ExpW-1:0]   MinExpRst    = 5'd12;
  localparam logic [ExpW-1:0]   DoublingsRst = 5'd8;
  localparam logic [CountW-1:0] RedundRst    = 8'd10;

  typedef enum logic [1:0] {
    OP_EXPIRED      = 2'd0,
    OP_CONSISTENT   = 2'd1,
    OP_INCONSISTENT = 2'd2,
    OP_START        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MIN_EXP   = 2'd0,
    REG_DOUBLINGS = 2'd1,
    REG_REDUNDANCY = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ExpW-1:0]   min_exponent;
    logic [ExpW-1:0]   doublings;
    logic [CountW-1:0] redundancy_limit;
  } cfg_t;

  typedef struct packed {
    logic [ExpW-1:0]   exponent;
    logic [CountW-1:0] heard;
    logic              fire_pending;
    logic [DelayW-1:0] rest;
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              send;
    logic [DelayW-1:0] delay;
    logic [ExpW-1:0]   exponent;
  } result_t;

endpackage

/* rtl/core/tit_step.sv */
`timescale 1ns / 1ps

// One event against the current timer state; purely combinational.
module tit_step (
  input  tit_pkg::op_t                op,
  input  logic [tit_pkg::RandW-1:0]   rnd,
  input  tit_pkg::cfg_t               cfg,
  input  tit_pkg::state_t             st,
  output tit_pkg::state_t             st_nxt,
  output tit_pkg::result_t            res
);

  logic [tit_pkg::ExpW-1:0]   floor_exp;
  logic [tit_pkg::ExpW:0]     ceil_sum;
  logic [tit_pkg::ExpW-1:0]   ceil_exp;
  logic [tit_pkg::ExpW-1:0]   exp_open;
  logic                       do_open;
  logic [24:0]                rnd_scaled;
  logic [46:0]                frac_full;
  logic [30:0]                half_len;
  logic [tit_pkg::DelayW-1:0] len;
  logic [tit_pkg::DelayW-1:0] fire;

  assign floor_exp = (cfg.min_exponent > tit_pkg::ExpCap) ? tit_pkg::ExpCap : cfg.min_exponent;
  assign ceil_sum  = {1'b0, cfg.min_exponent} + {1'b0, cfg.doublings};
  assign ceil_exp  = (ceil_sum > {1'b0, tit_pkg::ExpCap}) ? tit_pkg::ExpCap
                                                          : ceil_sum[tit_pkg::ExpW-1:0];

  // interval arithmetic at the exponent of the interval being opened
  assign rnd_scaled = 25'(tit_pkg::HalfUnit) * 25'(rnd);
  assign frac_full  = {22'd0, rnd_scaled} << exp_open;
  assign half_len   = 31'(tit_pkg::HalfUnit) << exp_open;
  assign len        = 32'(tit_pkg::Unit) << exp_open;
  assign fire       = {1'b0, half_len} + {1'b0, frac_full[46:16]};

  always_comb begin
    exp_open = st.exponent;
    do_open  = 1'b0;
    st_nxt   = st;
    res      = '0;
    case (op)
      tit_pkg::OP_EXPIRED: begin
        if (st.fire_pending) begin
          st_nxt.fire_pending = 1'b0;
          res.valid    = 1'b1;
          res.send     = (st.heard < cfg.redundancy_limit);
          res.delay    = st.rest;
        end else begin
          do_open = 1'b1;
          if (st.exponent < ceil_exp) begin
            exp_open = st.exponent + 5'd1;
          end
        end
      end
      tit_pkg::OP_CONSISTENT: begin
        if (st.heard != tit_pkg::CountMax) begin
          st_nxt.heard = st.heard + 8'd1;
        end
      end
      tit_pkg::OP_INCONSISTENT: begin
        if (st.exponent > floor_exp) begin
          do_open  = 1'b1;
          exp_open = floor_exp;
        end
      end
      tit_pkg::OP_START: begin
        do_open  = 1'b1;
        exp_open = floor_exp;
      end
      default: begin
        st_nxt = st;
      end
    endcase

    if (do_open) begin
      st_nxt.exponent     = exp_open;
      st_nxt.rest         = len - fire;
      st_nxt.fire_pending = 1'b1;
      st_nxt.heard        = '0;
      res.valid           = 1'b1;
      res.send            = 1'b0;
      res.delay           = fire;
    end
    res.exponent = st_nxt.exponent;
  end

endmodule

/* rtl/core/trickle_interval_timer_core.sv */
`timescale 1ns / 1ps
// An event in the input register is processed once the result register is free or being
// emptied, and its result is then registered there. Throughput: one event per cycle while
// the result stream is not stalled; the state update of each event closes within that cycle.
// Events that make no result (consistent heard, inconsistency at minimum) still use a slot.
// Reset (rst_n low, synchronous): pipeline empty, timer state zero, registers back to
// min_exponent 12, doublings 8, redundancy_limit 10.
module trickle_interval_timer_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] random_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] send_message, [32:1] next_delay,
                                  // [37:33] interval_exponent, [39:38] zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  tit_pkg::cfg_t     cfg_r;
  tit_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = tit_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_exponent     <= tit_pkg::MinExpRst;
      cfg_r.doublings        <= tit_pkg::DoublingsRst;
      cfg_r.redundancy_limit <= tit_pkg::RedundRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        tit_pkg::REG_MIN_EXP:    cfg_r.min_exponent     <= cfg_pwdata[4:0];
        tit_pkg::REG_DOUBLINGS:  cfg_r.doublings        <= cfg_pwdata[4:0];
        tit_pkg::REG_REDUNDANCY: cfg_r.redundancy_limit <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tit_pkg::REG_MIN_EXP:    cfg_prdata = {27'd0, cfg_r.min_exponent};
      tit_pkg::REG_DOUBLINGS:  cfg_prdata = {27'd0, cfg_r.doublings};
      tit_pkg::REG_REDUNDANCY: cfg_prdata = {24'd0, cfg_r.redundancy_limit};
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register stage. The event in it is processed when the result
  // register is free or being emptied in the same cycle.
  // ---------------------------------------------------------------------
  logic                        s1_v_r;
  tit_pkg::op_t                s1_op_r;
  logic [tit_pkg::RandW-1:0]   s1_rnd_r;
  logic                        out_free;
  logic                        advance;

  assign out_free  = ~out_tvalid | out_tready;
  assign advance   = s1_v_r & out_free;
  assign in_tready = ~s1_v_r | out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= tit_pkg::op_t'(in_tuser);
      s1_rnd_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------------
  // Timer state and step logic
  // ---------------------------------------------------------------------
  tit_pkg::state_t  st_r;
  tit_pkg::state_t  st_nxt;
  tit_pkg::result_t res;

  tit_step u_step (
    .op     (s1_op_r),
    .rnd    (s1_rnd_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register; holds until the downstream transfer completes.
  // ---------------------------------------------------------------------
  logic                       out_v_r;
  logic                       out_send_r;
  logic [tit_pkg::DelayW-1:0] out_delay_r;
  logic [tit_pkg::ExpW-1:0]   out_exp_r;
  logic                       out_v_nxt;

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (advance && res.valid) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_send_r  <= res.send;
      out_delay_r <= res.delay;
      out_exp_r   <= res.exponent;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_exp_r, out_delay_r, out_send_r};

endmodule

/* rtl/core/tit_checker.sv */
`timescale 1ns / 1ps

module tit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // exponent never exceeds the cap
  a_exp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:33] <= tit_pkg::ExpCap)
    else $error("interval exponent above cap");

  // both firing delay and remainder are always non-zero
  a_delay_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32:1] != 32'd0)
    else $error("zero delay in result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind trickle_interval_timer_core tit_checker u_tit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
